/* rtl/assert_macros.svh */
// assertion macros shared by the gf2 reduction rtl
// no dependencies; the checking forms drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GJF_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GJF_ASSERT(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GJF_ASSERT_RST(label, clk, rst_n, prop, msg)
`define GJF_ASSERT(label, clk, prop, msg)
`endif
`endif

/* rtl/gjf_pkg.sv */
// shared types and constants of the gf2 gauss-jordan reduction block
// no dependencies; used by gjf_ctrl, gjf_dp and gf2_gauss_jordan_freecols
`timescale 1ns / 1ps

package gjf_pkg;

  localparam int unsigned ROW_W        = 64;
  localparam int unsigned IDX_W        = 6;
  localparam int unsigned ACOL_W       = 7;
  localparam int unsigned OUT_ROW_LSB  = IDX_W;
  localparam int unsigned OUT_FREE_LSB = IDX_W + ROW_W;
  localparam int unsigned OUT_TDATA_W  = 136;
  localparam int unsigned APB_AW       = 3;
  localparam int unsigned APB_DW       = 32;

  localparam logic [ACOL_W-1:0] ACTIVE_COLS_RST = 7'd64;
  // word index of the register within the apb window
  localparam logic REG_ACTIVE_COLS = 1'b0;

  typedef enum logic [1:0] {
    WR_IN,
    WR_PIV,
    WR_XOR
  } wr_sel_e;

  typedef struct packed {
    logic    rd_en;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    piv_ld;
    logic    below_clr;
    logic    below_acc;
    logic    fm_clr;
    logic    fm_set;
    logic    out_ld;
    logic    out_last;
  } cmd_t;

  typedef struct packed {
    logic rd_bit;
    logic eval_bit;
    logic out_free;
  } sts_t;

endpackage

/* rtl/gjf_dp.sv */
// datapath: row memory, pivot and accumulator rows, free mask, output word register
// depends on gjf_pkg; driven by gjf_ctrl commands
`timescale 1ns / 1ps

module gjf_dp #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gjf_pkg::cmd_t                       cmd_i,
  input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] rd_addr_i,
  input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] wr_addr_i,
  input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] col_i,
  input  logic [$clog2(MAX_COLS + 1)-1:0]     nc_i,
  input  logic [gjf_pkg::ROW_W-1:0]           in_row_i,
  input  logic [gjf_pkg::IDX_W-1:0]           out_idx_i,
  input  logic                                out_ovf_i,
  output gjf_pkg::sts_t                       sts_o,
  input  logic                                m_tready_i,
  output logic                                m_tvalid_o,
  output logic [gjf_pkg::OUT_TDATA_W-1:0]     m_tdata_o,
  output logic                                m_tuser_o,
  output logic                                m_tlast_o
);

  localparam int JW = $clog2(MAX_COLS + 1);

  logic [MAX_COLS-1:0] mem_q [MAX_ROWS];
  logic [MAX_COLS-1:0] rd_q;
  logic [MAX_COLS-1:0] piv_q;
  logic [MAX_COLS-1:0] below_q;
  logic [MAX_COLS-1:0] fm_q;
  logic [MAX_COLS-1:0] col_mask;
  logic [MAX_COLS-1:0] wdata;

  logic                     out_vld_q;
  logic [gjf_pkg::IDX_W-1:0] out_idx_q;
  logic [MAX_COLS-1:0]      out_row_q;
  logic [MAX_COLS-1:0]      out_fm_q;
  logic                     out_ovf_q;
  logic                     out_last_q;

  always_comb begin
    for (int j = 0; j < MAX_COLS; j++) begin
      col_mask[j] = (JW'(j) < nc_i);
    end
  end

  always_comb begin
    unique case (cmd_i.wr_sel)
      gjf_pkg::WR_IN:  wdata = in_row_i[MAX_COLS-1:0] & col_mask;
      gjf_pkg::WR_PIV: wdata = piv_q;
      gjf_pkg::WR_XOR: wdata = rd_q ^ piv_q;
      default:         wdata = piv_q;
    endcase
  end

  // row memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr_i] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.piv_ld) begin
      piv_q <= rd_q;
    end
    if (cmd_i.below_clr) begin
      below_q <= '0;
    end else if (cmd_i.below_acc) begin
      below_q <= below_q | rd_q;
    end
    if (cmd_i.fm_clr) begin
      fm_q <= '0;
    end else if (cmd_i.fm_set) begin
      fm_q[col_i] <= 1'b1;
    end
    if (cmd_i.out_ld) begin
      out_idx_q  <= out_idx_i;
      out_row_q  <= rd_q;
      out_fm_q   <= cmd_i.out_last ? fm_q : '0;
      out_ovf_q  <= out_ovf_i;
      out_last_q <= cmd_i.out_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_vld_q <= 1'b1;
    end else if (m_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign sts_o.rd_bit   = rd_q[col_i];
  assign sts_o.eval_bit = piv_q[col_i] | below_q[col_i];
  assign sts_o.out_free = !out_vld_q || m_tready_i;

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = {2'b00, gjf_pkg::ROW_W'(out_fm_q), gjf_pkg::ROW_W'(out_row_q), out_idx_q};
  assign m_tuser_o  = out_ovf_q;
  assign m_tlast_o  = out_last_q;

endmodule

/* rtl/gjf_ctrl.sv */
// controller: load, pivot search and swap, elimination, staircase scan, emit
// depends on gjf_pkg; commands gjf_dp
`timescale 1ns / 1ps

module gjf_ctrl #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_last_i,
  output logic                                in_ready_o,
  input  logic [$clog2(MAX_COLS + 1)-1:0]     nc_i,
  input  gjf_pkg::sts_t                       sts_i,
  output gjf_pkg::cmd_t                       cmd_o,
  output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] rd_addr_o,
  output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] wr_addr_o,
  output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] col_o,
  output logic [gjf_pkg::IDX_W-1:0]           out_idx_o,
  output logic                                out_ovf_o
);

  localparam int RW  = $clog2(MAX_ROWS + 1);
  localparam int JW  = $clog2(MAX_COLS + 1);
  localparam int AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CMW = (RW > JW) ? RW : JW;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PIV_RD,
    ST_PIV_CHK,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_SWAP_WR,
    ST_ELIM_RD,
    ST_ELIM_WR,
    ST_FREE_RD,
    ST_FREE_LD,
    ST_BELOW_RD,
    ST_BELOW_ACC,
    ST_FREE_EVAL,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_e;

  state_e        state_q;
  logic [RW-1:0] nr_q;
  logic [RW-1:0] k_q;
  logic [RW-1:0] i_q;
  logic [JW-1:0] p_q;
  logic          ovf_q;

  logic [CMW-1:0] nr_ext, nc_ext, k1, p1, i1;
  logic           nr_full, k1_end, p1_rend, p1_cend, i1_end, col_done, k_is_p;

  assign nr_ext   = CMW'(nr_q);
  assign nc_ext   = CMW'(nc_i);
  assign k1       = CMW'(k_q) + CMW'(1);
  assign p1       = CMW'(p_q) + CMW'(1);
  assign i1       = CMW'(i_q) + CMW'(1);
  assign nr_full  = (nr_ext >= CMW'(MAX_ROWS));
  assign k1_end   = (k1 >= nr_ext);
  assign p1_rend  = (p1 >= nr_ext);
  assign p1_cend  = (p1 >= nc_ext);
  assign i1_end   = (i1 >= nr_ext);
  assign col_done = p1_rend || p1_cend;
  assign k_is_p   = (CMW'(k_q) == CMW'(p_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      nr_q    <= '0;
      k_q     <= '0;
      i_q     <= '0;
      p_q     <= '0;
      ovf_q   <= 1'b0;
    end else begin
      unique case (state_q)
        ST_LOAD: begin
          if (in_valid_i) begin
            if (!nr_full) begin
              nr_q <= nr_q + RW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            if (in_last_i) begin
              p_q     <= '0;
              state_q <= ST_PIV_RD;
            end
          end
        end
        ST_PIV_RD: state_q <= ST_PIV_CHK;
        ST_PIV_CHK: begin
          if (sts_i.rd_bit) begin
            k_q     <= '0;
            state_q <= ST_ELIM_RD;
          end else if (p1_rend) begin
            p_q     <= '0;
            i_q     <= '0;
            state_q <= ST_FREE_RD;
          end else begin
            k_q     <= RW'(p1);
            state_q <= ST_SRCH_RD;
          end
        end
        ST_SRCH_RD: state_q <= ST_SRCH_CHK;
        ST_SRCH_CHK: begin
          if (sts_i.rd_bit) begin
            state_q <= ST_SWAP_WR;
          end else if (k1_end) begin
            p_q     <= col_done ? '0 : JW'(p1);
            i_q     <= '0;
            state_q <= col_done ? ST_FREE_RD : ST_PIV_RD;
          end else begin
            k_q     <= RW'(k1);
            state_q <= ST_SRCH_RD;
          end
        end
        ST_SWAP_WR: begin
          k_q     <= '0;
          state_q <= ST_ELIM_RD;
        end
        ST_ELIM_RD: state_q <= ST_ELIM_WR;
        ST_ELIM_WR: begin
          if (k1_end) begin
            p_q     <= col_done ? '0 : JW'(p1);
            i_q     <= '0;
            state_q <= col_done ? ST_FREE_RD : ST_PIV_RD;
          end else begin
            k_q     <= RW'(k1);
            state_q <= ST_ELIM_RD;
          end
        end
        ST_FREE_RD: state_q <= ST_FREE_LD;
        ST_FREE_LD: begin
          k_q     <= RW'(i1);
          state_q <= i1_end ? ST_FREE_EVAL : ST_BELOW_RD;
        end
        ST_BELOW_RD: state_q <= ST_BELOW_ACC;
        ST_BELOW_ACC: begin
          if (k1_end) begin
            state_q <= ST_FREE_EVAL;
          end else begin
            k_q     <= RW'(k1);
            state_q <= ST_BELOW_RD;
          end
        end
        ST_FREE_EVAL: begin
          p_q <= JW'(p1);
          if (sts_i.eval_bit) begin
            i_q <= RW'(i1);
            if (i1_end || p1_cend) begin
              k_q     <= '0;
              state_q <= ST_EMIT_RD;
            end else begin
              state_q <= ST_FREE_RD;
            end
          end else if (p1_cend) begin
            k_q     <= '0;
            state_q <= ST_EMIT_RD;
          end
        end
        ST_EMIT_RD: state_q <= ST_EMIT_LD;
        ST_EMIT_LD: begin
          if (sts_i.out_free) begin
            if (k1_end) begin
              nr_q    <= '0;
              ovf_q   <= 1'b0;
              state_q <= ST_LOAD;
            end else begin
              k_q     <= RW'(k1);
              state_q <= ST_EMIT_RD;
            end
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.wr_sel = gjf_pkg::WR_PIV;
    rd_addr_o  = AW'(k_q);
    wr_addr_o  = AW'(k_q);
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o   = 1'b1;
        cmd_o.fm_clr = 1'b1;
        cmd_o.wr_en  = in_valid_i && !nr_full;
        cmd_o.wr_sel = gjf_pkg::WR_IN;
        wr_addr_o    = AW'(nr_q);
      end
      ST_PIV_RD: begin
        cmd_o.rd_en = 1'b1;
        rd_addr_o   = AW'(p_q);
      end
      ST_PIV_CHK:  cmd_o.piv_ld = 1'b1;
      ST_SRCH_RD:  cmd_o.rd_en  = 1'b1;
      ST_SRCH_CHK: begin
        // old pivot row goes down, found row becomes the pivot
        cmd_o.wr_en  = sts_i.rd_bit;
        cmd_o.piv_ld = sts_i.rd_bit;
      end
      ST_SWAP_WR: begin
        cmd_o.wr_en = 1'b1;
        wr_addr_o   = AW'(p_q);
      end
      ST_ELIM_RD: cmd_o.rd_en = 1'b1;
      ST_ELIM_WR: begin
        cmd_o.wr_en  = sts_i.rd_bit && !k_is_p;
        cmd_o.wr_sel = gjf_pkg::WR_XOR;
      end
      ST_FREE_RD: begin
        cmd_o.rd_en = 1'b1;
        rd_addr_o   = AW'(i_q);
      end
      ST_FREE_LD: begin
        cmd_o.piv_ld    = 1'b1;
        cmd_o.below_clr = 1'b1;
      end
      ST_BELOW_RD:  cmd_o.rd_en     = 1'b1;
      ST_BELOW_ACC: cmd_o.below_acc = 1'b1;
      ST_FREE_EVAL: cmd_o.fm_set    = !sts_i.eval_bit;
      ST_EMIT_RD:   cmd_o.rd_en     = 1'b1;
      ST_EMIT_LD: begin
        cmd_o.out_ld   = sts_i.out_free;
        cmd_o.out_last = k1_end;
      end
      default: cmd_o = '0;
    endcase
  end

  assign col_o     = CIW'(p_q);
  assign out_idx_o = gjf_pkg::IDX_W'(k_q);
  assign out_ovf_o = ovf_q;

endmodule

/* rtl/gf2_gauss_jordan_freecols.sv */
// Rows load one per cycle while the block is loading; one matrix is worked at a time. After
// the last row, reduction reads the pivot row of each column, searches the rows below it for
// a pivot, swaps if one is found, then clears the column from every other row. The staircase
// scan loads each row step, ORs in the rows below it and evaluates each column; emit reads each
// row and waits on the receiver. All of it uses one read and one write port of the row memory.
// Reset clears control state and sets active_cols to 64; row memory is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gf2_gauss_jordan_freecols #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [gjf_pkg::ROW_W-1:0]          s_axis_tdata_i,  // row_bits
  input  logic                               s_axis_tlast_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // row_index, row_bits_out, free_columns, zero pad
  output logic [gjf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  output logic                               m_axis_tuser_o,  // overflow
  output logic                               m_axis_tlast_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gjf_pkg::APB_AW-1:0]         paddr,
  input  logic [gjf_pkg::APB_DW-1:0]         pwdata,
  output logic [gjf_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);

  localparam int JW  = $clog2(MAX_COLS + 1);
  localparam int AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [gjf_pkg::ACOL_W-1:0] active_cols_q, active_cols_d;
  logic                       cfg_we;
  logic [JW-1:0]              nc;

  gjf_pkg::cmd_t             cmd;
  gjf_pkg::sts_t             sts;
  logic [AW-1:0]             rd_addr, wr_addr;
  logic [CIW-1:0]            col;
  logic [gjf_pkg::IDX_W-1:0] out_idx;
  logic                      out_ovf;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == gjf_pkg::REG_ACTIVE_COLS);
  assign active_cols_d = cfg_we ? pwdata[gjf_pkg::ACOL_W-1:0] : active_cols_q;
  assign prdata = (paddr[2] == gjf_pkg::REG_ACTIVE_COLS) ?
                  gjf_pkg::APB_DW'(active_cols_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_cols_q <= gjf_pkg::ACTIVE_COLS_RST;
    end else begin
      active_cols_q <= active_cols_d;
    end
  end

  // clamp to 1..MAX_COLS
  always_comb begin
    priority if (active_cols_q == '0) begin
      nc = JW'(1);
    end else if (active_cols_q > gjf_pkg::ACOL_W'(MAX_COLS)) begin
      nc = JW'(MAX_COLS);
    end else begin
      nc = JW'(active_cols_q);
    end
  end

  gjf_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .nc_i       (nc),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr),
    .wr_addr_o  (wr_addr),
    .col_o      (col),
    .out_idx_o  (out_idx),
    .out_ovf_o  (out_ovf)
  );

  gjf_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (wr_addr),
    .col_i      (col),
    .nc_i       (nc),
    .in_row_i   (s_axis_tdata_i),
    .out_idx_i  (out_idx),
    .out_ovf_i  (out_ovf),
    .sts_o      (sts),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

  `GJF_ASSERT_RST(a_free_only_on_last, clk_i, rst_ni, (m_axis_tvalid_o && !m_axis_tlast_o) |-> (m_axis_tdata_o[gjf_pkg::OUT_TDATA_W-3:gjf_pkg::OUT_FREE_LSB] == '0), "free mask set on a word that is not last")
  `GJF_ASSERT(a_row_index_range, clk_i, m_axis_tvalid_o |-> (m_axis_tdata_o[gjf_pkg::IDX_W-1:0] < MAX_ROWS), "row index beyond capacity")

endmodule

/* test/testbench.sv */
// self-checking testbench of gf2_gauss_jordan_freecols: streams bit matrices, predicts the
// reduced rows and free-column mask of each one and compares every word that comes out
// depends on gjf_pkg and the rtl of the block
`timescale 1ns / 1ps

module testbench;
  import gjf_pkg::*;

  localparam int MAX_ROWS    = 32;
  localparam int MAX_COLS    = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 40;
  localparam int NUM_PHASES  = 9;
  localparam int PHASE_ROWS  = 7;
  localparam logic [APB_AW-1:0] ADDR_ACTIVE_COLS = {REG_ACTIVE_COLS, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_SPARE       = {~REG_ACTIVE_COLS, 2'b00};

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [ROW_W-1:0] bits;
    logic [ROW_W-1:0] free_cols;
    logic             ovf;
    logic             last;
  } reduced_row_t;

  class gf2_reduction_board;
    logic [ROW_W-1:0]  mat [MAX_ROWS];
    int                loaded;
    logic              ovf;
    logic [ACOL_W-1:0] acols;
    reduced_row_t      rows_due [$];
    int                errors;

    function new();
      loaded = 0;
      ovf    = 1'b0;
      acols  = ACTIVE_COLS_RST;
      errors = 0;
    endfunction

    function void set_cols(logic [ACOL_W-1:0] v);
      acols = v;
    endfunction

    function int col_count();
      int n;
      n = int'(acols);
      if (n < 1) n = 1;
      if (n > MAX_COLS) n = MAX_COLS;
      return n;
    endfunction

    function void reduce_matrix(int nr, int nc);
      int diag;
      int k;
      logic [ROW_W-1:0] t;
      diag = nr < nc ? nr : nc;
      for (int i = 0; i < diag; i++) begin
        if (!mat[i][i]) begin
          k = i + 1;
          while (k < nr && !mat[k][i]) k++;
          if (k >= nr) continue;
          t      = mat[i];
          mat[i] = mat[k];
          mat[k] = t;
        end
        for (int r = 0; r < nr; r++)
          if (r != i && mat[r][i]) mat[r] ^= mat[i];
      end
    endfunction

    // staircase walk over the reduced matrix
    function logic [ROW_W-1:0] scan_free_columns(int nr, int nc);
      logic [ROW_W-1:0] fm;
      int i;
      int j;
      int k;
      bit adv;
      fm = '0;
      i  = 0;
      j  = 0;
      while (i < nr && j < nc) begin
        adv = 1'b1;
        if (!mat[i][j]) begin
          k = i + 1;
          while (k < nr && !mat[k][j]) k++;
          if (k >= nr) begin
            fm[j] = 1'b1;
            adv   = 1'b0;
          end
        end
        if (adv) i++;
        j++;
      end
      return fm;
    endfunction

    function void note_row(logic [ROW_W-1:0] bits, logic last_row);
      int nc;
      logic [ROW_W-1:0] msk;
      logic [ROW_W-1:0] fm;
      nc  = col_count();
      msk = nc >= 64 ? {ROW_W{1'b1}} : (64'd1 << nc) - 64'd1;
      if (loaded < MAX_ROWS) begin
        mat[loaded] = bits & msk;
        loaded++;
      end else begin
        ovf = 1'b1;
      end
      if (!last_row) return;
      reduce_matrix(loaded, nc);
      fm = scan_free_columns(loaded, nc);
      for (int r = 0; r < loaded; r++)
        rows_due.push_back('{IDX_W'(r), mat[r], (r == loaded - 1) ? fm : 64'd0, ovf,
                             r == loaded - 1});
      loaded = 0;
      ovf    = 1'b0;
    endfunction

    function void field_diff(string name, logic [ROW_W-1:0] exp_v, logic [ROW_W-1:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_row(logic [OUT_TDATA_W-1:0] tdata, logic ovf_o, logic last_o);
      reduced_row_t e;
      if (rows_due.size() == 0) begin
        $display("%0t: unexpected word expected none actual %h", $time, tdata);
        errors++;
        return;
      end
      e = rows_due.pop_front();
      field_diff("row_index", 64'(e.idx), 64'(tdata[IDX_W-1:0]));
      field_diff("row_bits_out", e.bits, tdata[OUT_ROW_LSB +: ROW_W]);
      field_diff("free_columns", e.free_cols, tdata[OUT_FREE_LSB +: ROW_W]);
      field_diff("overflow", 64'(e.ovf), 64'(ovf_o));
      field_diff("last", 64'(e.last), 64'(last_o));
    endfunction
  endclass

  logic                   clk_i    = 1'b0;
  logic                   rst_ni   = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic [ROW_W-1:0]       s_tdata  = '0;
  logic                   s_tlast  = 1'b0;
  logic                   m_ready  = 1'b0;
  logic                   psel     = 1'b0;
  logic                   penable  = 1'b0;
  logic                   pwrite   = 1'b0;
  logic [APB_AW-1:0]      paddr    = '0;
  logic [APB_DW-1:0]      pwdata   = '0;
  wire                    s_tready;
  wire                    m_tvalid;
  wire [OUT_TDATA_W-1:0]  m_tdata;
  wire                    m_tuser;
  wire                    m_tlast;
  wire [APB_DW-1:0]       prdata;
  wire                    pready;

  gf2_reduction_board sb;
  int          cycle_cnt  = 0;
  int          burst_left = 0;
  bit          idle_on    = 1'b0;
  bit          stall_on   = 1'b0;
  logic [12:0] stall_pat  = '1;
  int          stall_ph   = 0;

  gf2_gauss_jordan_freecols #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tlast_o (m_tlast),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver stalls on a repeating 13-bit pattern while stalling is on
  always @(posedge clk_i) begin
    m_ready  <= stall_on ? stall_pat[stall_ph] : 1'b1;
    stall_ph <= stall_ph == 12 ? 0 : stall_ph + 1;
  end

  always @(posedge clk_i)
    if (rst_ni && m_tvalid && m_ready) sb.check_row(m_tdata, m_tuser, m_tlast);

  task automatic send_row(input logic [ROW_W-1:0] bits, input logic last_row);
    int gap;
    if (burst_left == 0) begin
      gap = idle_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= bits;
    s_tlast  <= last_row;
    do @(posedge clk_i); while (!s_tready);
    sb.note_row(bits, last_row);
  endtask

  function automatic logic [ROW_W-1:0] pick_row(logic [ROW_W-1:0] pa, logic [ROW_W-1:0] pb);
    logic [ROW_W-1:0] r;
    case ($urandom_range(0, 6))
      0, 1: r = {$urandom, $urandom};
      2: r = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      3: r = 64'd1 << $urandom_range(0, 63);
      4: r = pa ^ pb;
      5: r = {$urandom, $urandom} & ((64'd1 << $urandom_range(1, 8)) - 64'd1);
      default: r = $urandom_range(0, 1) ? {ROW_W{1'b1}} : '0;
    endcase
    return r;
  endfunction

  task automatic send_matrix(input int nrows);
    logic [ROW_W-1:0] pa;
    logic [ROW_W-1:0] pb;
    logic [ROW_W-1:0] r;
    pa = '0;
    pb = '0;
    for (int n = 0; n < nrows; n++) begin
      r  = pick_row(pa, pb);
      pb = pa;
      pa = r;
      send_row(r, n == nrows - 1);
    end
  endtask

  function automatic int pick_height();
    int u;
    u = $urandom_range(0, 19);
    if (u == 0) return $urandom_range(28, 33);
    if (u < 4) return $urandom_range(7, 16);
    return $urandom_range(1, 6);
  endfunction

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.rows_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read(input logic [APB_AW-1:0] addr, output logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [ACOL_W-1:0] acol_set [NUM_PHASES];
    logic [APB_DW-1:0] wd;
    logic [APB_DW-1:0] rd;
    int sent;
    int h;
    acol_set = '{7'd0, 7'd1, 7'd127, 7'd64, 7'd3, 7'd100, 7'd33, 7'd63, 7'd64};
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // single rows, swap, skipped column, dependent rows, top column
    send_row({ROW_W{1'b1}}, 1'b1);
    send_row('0, 1'b1);
    send_row(64'h2, 1'b0);
    send_row(64'h1, 1'b0);
    send_row(64'h4, 1'b1);
    send_row(64'h2, 1'b0);
    send_row(64'h6, 1'b0);
    send_row(64'h8, 1'b1);
    send_row(64'hF0F0, 1'b0);
    send_row(64'hF0F0, 1'b1);
    send_row(64'h8000_0000_0000_0001, 1'b0);
    send_row({ROW_W{1'b1}}, 1'b0);
    send_row(64'h5555_5555_AAAA_AAAA, 1'b1);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wd = $urandom;
      wd[ACOL_W-1:0] = acol_set[ph];
      apb_write(ADDR_ACTIVE_COLS, wd);
      sb.set_cols(acol_set[ph]);
      apb_write(ADDR_SPARE, $urandom);
      apb_read(ADDR_ACTIVE_COLS, rd);
      if (rd[ACOL_W-1:0] !== acol_set[ph]) begin
        $display("%0t: active_cols readback expected %h actual %h", $time, acol_set[ph],
                 rd[ACOL_W-1:0]);
        sb.errors++;
      end
      idle_on   = $urandom_range(0, 3) != 0;
      stall_on  = $urandom_range(0, 3) != 0;
      stall_pat = $urandom_range(0, 1) ? (13'($urandom) | 13'h1) :
                                         (13'($urandom & $urandom) | 13'h1);
      sent = 0;
      // overflow runs: two dropped rows, the final one among them, then a single dropped final row
      if (ph == 2) begin
        send_matrix(34);
        sent += 34;
      end else if (ph == 6) begin
        send_matrix(33);
        sent += 33;
      end
      while (sent < PHASE_ROWS) begin
        h = pick_height();
        send_matrix(h);
        sent += h;
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
